// File: design/hlpi_pkg.sv
package hlpi_pkg;

  localparam int MaxLinesDefault = 32;
  localparam int CoordFracDefault = 4;
  localparam int RhoW = 14;
  localparam int ThetaW = 8;
  localparam int CoordW = 16;
  localparam int ImgW = 12;
  localparam int TrigW = 16;
  localparam logic [ImgW-1:0] WidthReset = 12'd640;
  localparam logic [ImgW-1:0] HeightReset = 12'd480;
  localparam logic CfgIdxWidth = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  typedef struct packed {
    logic signed [RhoW-1:0] rho;
    logic [ThetaW-1:0] theta;
    logic vert;
  } line_t;

  typedef struct packed {
    line_t cur;
    line_t other;
    logic last;
  } pair_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SCAN,
    FR_STORE
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TRIG,
    BK_MUL,
    BK_SUM,
    BK_CHECK,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // sin(k deg) for k = 0..90, signed Q1.14, built by repeated one-degree rotation
  function automatic logic signed [TrigW-1:0] sin_rom(input logic [6:0] k);
    logic signed [TrigW-1:0] v;
    case (k)
      7'd0: v = 16'sd0;      7'd1: v = 16'sd286;    7'd2: v = 16'sd572;
      7'd3: v = 16'sd857;    7'd4: v = 16'sd1143;   7'd5: v = 16'sd1428;
      7'd6: v = 16'sd1713;   7'd7: v = 16'sd1997;   7'd8: v = 16'sd2280;
      7'd9: v = 16'sd2563;   7'd10: v = 16'sd2845;  7'd11: v = 16'sd3126;
      7'd12: v = 16'sd3406;  7'd13: v = 16'sd3686;  7'd14: v = 16'sd3964;
      7'd15: v = 16'sd4240;  7'd16: v = 16'sd4516;  7'd17: v = 16'sd4790;
      7'd18: v = 16'sd5063;  7'd19: v = 16'sd5334;  7'd20: v = 16'sd5604;
      7'd21: v = 16'sd5872;  7'd22: v = 16'sd6138;  7'd23: v = 16'sd6402;
      7'd24: v = 16'sd6664;  7'd25: v = 16'sd6924;  7'd26: v = 16'sd7182;
      7'd27: v = 16'sd7438;  7'd28: v = 16'sd7692;  7'd29: v = 16'sd7943;
      7'd30: v = 16'sd8192;  7'd31: v = 16'sd8438;  7'd32: v = 16'sd8682;
      7'd33: v = 16'sd8923;  7'd34: v = 16'sd9162;  7'd35: v = 16'sd9397;
      7'd36: v = 16'sd9630;  7'd37: v = 16'sd9860;  7'd38: v = 16'sd10087;
      7'd39: v = 16'sd10311; 7'd40: v = 16'sd10531; 7'd41: v = 16'sd10749;
      7'd42: v = 16'sd10963; 7'd43: v = 16'sd11174; 7'd44: v = 16'sd11381;
      7'd45: v = 16'sd11585; 7'd46: v = 16'sd11786; 7'd47: v = 16'sd11982;
      7'd48: v = 16'sd12176; 7'd49: v = 16'sd12365; 7'd50: v = 16'sd12551;
      7'd51: v = 16'sd12733; 7'd52: v = 16'sd12911; 7'd53: v = 16'sd13085;
      7'd54: v = 16'sd13255; 7'd55: v = 16'sd13421; 7'd56: v = 16'sd13583;
      7'd57: v = 16'sd13741; 7'd58: v = 16'sd13894; 7'd59: v = 16'sd14044;
      7'd60: v = 16'sd14189; 7'd61: v = 16'sd14330; 7'd62: v = 16'sd14466;
      7'd63: v = 16'sd14598; 7'd64: v = 16'sd14726; 7'd65: v = 16'sd14849;
      7'd66: v = 16'sd14968; 7'd67: v = 16'sd15082; 7'd68: v = 16'sd15191;
      7'd69: v = 16'sd15296; 7'd70: v = 16'sd15396; 7'd71: v = 16'sd15491;
      7'd72: v = 16'sd15582; 7'd73: v = 16'sd15668; 7'd74: v = 16'sd15749;
      7'd75: v = 16'sd15826; 7'd76: v = 16'sd15897; 7'd77: v = 16'sd15964;
      7'd78: v = 16'sd16026; 7'd79: v = 16'sd16083; 7'd80: v = 16'sd16135;
      7'd81: v = 16'sd16182; 7'd82: v = 16'sd16225; 7'd83: v = 16'sd16262;
      7'd84: v = 16'sd16294; 7'd85: v = 16'sd16322; 7'd86: v = 16'sd16344;
      7'd87: v = 16'sd16362; 7'd88: v = 16'sd16374; 7'd89: v = 16'sd16382;
      7'd90: v = 16'sd16384;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // sine of an angle already reduced to 0..359
  function automatic logic signed [TrigW-1:0] sine_deg(input logic [8:0] r);
    logic signed [TrigW-1:0] v;
    if (r <= 9'd90) begin
      v = sin_rom(r[6:0]);
    end else if (r <= 9'd180) begin
      v = sin_rom(7'(9'd180 - r));
    end else if (r <= 9'd270) begin
      v = -sin_rom(7'(r - 9'd180));
    end else begin
      v = -sin_rom(7'(9'd360 - r));
    end
    return v;
  endfunction

  // reduce a value in -359..719 to 0..359
  function automatic logic [8:0] wrap_deg(input logic signed [10:0] d);
    logic signed [10:0] t;
    t = d;
    if (t < 0) begin
      t = t + 11'sd360;
    end else if (t >= 11'sd360) begin
      t = t - 11'sd360;
    end
    return t[8:0];
  endfunction

endpackage

// File: design/hlpi_if.sv
interface hlpi_if #(
  parameter int W = 1
) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/hough_line_pair_intersection.sv
// channel  | dir | fields
// line_in  | in  | rho[13:0] theta_deg[7:0] new_set
// point_out| out  | point_x[15:0] point_y[15:0] last_point
// cfg      | in  | cfg_we cfg_index cfg_data[11:0]
// One line at a time: the front scans the store entry by entry while the queue can
// advance, with an extra step for each entry of the other class, passed through a
// one-entry queue to the back. The back drops a pair outside the image and runs a hit
// through the bit-serial divider; each point waits for the next to know its last flag.
// Reset is synchronous and empties the store; stalls on the output hold the back.
module hough_line_pair_intersection
  import hlpi_pkg::*;
#(
  parameter int MaxLines = MaxLinesDefault,
  parameter int CoordFrac = CoordFracDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [ImgW-1:0] cfg_data,
  input  logic line_in_valid,
  output logic line_in_ready,
  input  logic signed [RhoW-1:0] rho,
  input  logic [ThetaW-1:0] theta_deg,
  input  logic new_set,
  output logic point_out_valid,
  input  logic point_out_ready,
  output logic [CoordW-1:0] point_x,
  output logic [CoordW-1:0] point_y,
  output logic last_point
);

  logic [ImgW-1:0] image_width, image_height;
  logic q_valid, q_ready, back_idle, emitted;
  pair_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WidthReset;
      image_height <= HeightReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgIdxWidth) image_width <= cfg_data;
      if (cfg_index == CfgIdxHeight) image_height <= cfg_data;
    end
  end

  hlpi_front #(.MaxLines(MaxLines)) u_front (
    .clk, .rst,
    .in_valid(line_in_valid), .in_ready(line_in_ready),
    .in_rho(rho), .in_theta(theta_deg), .in_new_set(new_set),
    .q_valid, .q_ready, .q_data, .back_idle
  );

  hlpi_back #(.CoordFrac(CoordFrac)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .image_width, .image_height,
    .out_valid(point_out_valid), .out_ready(point_out_ready),
    .out_x(point_x), .out_y(point_y), .out_last(last_point),
    .idle(back_idle), .emitted
  );

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emitted |-> point_out_valid) else $error("emit without valid");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (line_in_valid && line_in_ready) |-> !point_out_valid)
    else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (point_out_valid && !point_out_ready) |=> point_out_valid)
    else $error("point dropped");

endmodule

// File: design/hlpi_front.sv
module hlpi_front
  import hlpi_pkg::*;
#(
  parameter int MaxLines = MaxLinesDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [RhoW-1:0] in_rho,
  input  logic [ThetaW-1:0] in_theta,
  input  logic in_new_set,
  output logic q_valid,
  input  logic q_ready,
  output pair_t q_data,
  input  logic back_idle
);

  localparam int IdxW = $clog2(MaxLines);
  localparam int CntW = $clog2(MaxLines + 1);

  front_state_t state, state_next;
  line_t store [MaxLines];
  line_t cur;
  line_t rd;
  line_t held;
  logic [CntW-1:0] count;
  logic [CntW-1:0] scan;
  logic have_last;
  logic rd_valid;
  logic take;
  logic advance;
  logic push;
  logic [CntW-1:0] eff_count;

  assign eff_count = in_new_set ? '0 : count;
  assign take = in_valid && in_ready;
  assign advance = !q_valid || q_ready;
  assign push = (state == FR_SCAN) && advance && have_last && (rd_valid || scan >= count);

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (take && eff_count < CntW'(MaxLines)) state_next = FR_SCAN;
      FR_SCAN: if (scan == count && !rd_valid && (!have_last || advance)) begin
        state_next = FR_STORE;
      end
      FR_STORE: if (!q_valid && back_idle) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == FR_IDLE) && !q_valid && back_idle;
  end

  // scan reads one store entry at a time while the queue advances; a matching
  // entry is held one step so the last pair of the line is known when queued
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      count <= '0;
      scan <= '0;
      rd_valid <= 1'b0;
      have_last <= 1'b0;
      q_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        q_valid <= 1'b1;
      end else if (q_ready) begin
        q_valid <= 1'b0;
      end
      case (state)
        FR_IDLE: begin
          if (take) begin
            count <= eff_count;
            cur <= '{rho: in_rho, theta: in_theta,
                     vert: (in_theta < 8'd45) || (in_theta > 8'd135)};
            scan <= '0;
            rd_valid <= 1'b0;
            have_last <= 1'b0;
          end
        end
        FR_SCAN: begin
          if (advance) begin
            if (rd_valid) begin
              if (have_last) begin
                q_data <= '{cur: cur, other: held, last: 1'b0};
              end
              held <= rd;
              have_last <= 1'b1;
              rd_valid <= 1'b0;
            end else if (scan < count) begin
              rd <= store[scan[IdxW-1:0]];
              scan <= scan + 1'b1;
              rd_valid <= store[scan[IdxW-1:0]].vert != cur.vert;
            end else if (have_last) begin
              q_data <= '{cur: cur, other: held, last: 1'b1};
              have_last <= 1'b0;
            end
          end
        end
        FR_STORE: begin
          if (!q_valid && back_idle && count < CntW'(MaxLines)) begin
            store[count[IdxW-1:0]] <= cur;
            count <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/hlpi_back.sv
module hlpi_back
  import hlpi_pkg::*;
#(
  parameter int CoordFrac = CoordFracDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  pair_t q_data,
  input  logic [ImgW-1:0] image_width,
  input  logic [ImgW-1:0] image_height,
  output logic out_valid,
  input  logic out_ready,
  output logic [CoordW-1:0] out_x,
  output logic [CoordW-1:0] out_y,
  output logic out_last,
  output logic idle,
  output logic emitted
);

  localparam int NumW = 48;
  localparam int DivSteps = ImgW + CoordFrac;
  localparam int StepW = $clog2(DivSteps + 1);

  back_state_t state, state_next;
  pair_t job;
  line_t lv, lh;
  logic signed [TrigW-1:0] a, b, m, n, d;
  logic signed [31:0] pb, nc, mc, pa;
  logic signed [NumW-1:0] nx, ny;
  logic signed [NumW-1:0] dd;
  logic hit;
  logic [ImgW+TrigW-1:0] limx, limy;
  logic [NumW-1:0] remx, remy, qx, qy;
  logic [StepW-1:0] step;
  logic pend_last;
  logic fresh;
  logic [CoordW-1:0] hold_x, hold_y, rx, ry;
  logic [NumW-1:0] shx, shy;
  logic [NumW:0] trx, try_;

  assign lv = job.cur.vert ? job.cur : job.other;
  assign lh = job.cur.vert ? job.other : job.cur;
  assign q_ready = (state == BK_IDLE) && !out_valid;
  assign idle = (state == BK_IDLE) && !out_valid && !pend_last;
  assign rx = (|qx[NumW-1:CoordW]) ? {CoordW{1'b1}} : qx[CoordW-1:0];
  assign ry = (|qy[NumW-1:CoordW]) ? {CoordW{1'b1}} : qy[CoordW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid && q_ready) state_next = BK_TRIG;
      BK_TRIG: state_next = BK_MUL;
      BK_MUL: state_next = BK_SUM;
      BK_SUM: state_next = BK_CHECK;
      BK_CHECK: begin
        if (hit) begin
          state_next = BK_DIV;
        end else if (job.last && pend_last) begin
          state_next = BK_OUT;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_DIV: if (step == StepW'(DivSteps - 1)) state_next = BK_OUT;
      BK_OUT: if (!out_valid) state_next = (fresh && job.last) ? BK_OUT : BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // restoring division, one quotient bit per cycle for x and y together
  always_comb begin
    shx = {remx[NumW-2:0], qx[NumW-1]};
    shy = {remy[NumW-2:0], qy[NumW-1]};
    trx = {1'b0, shx} - {1'b0, dd};
    try_ = {1'b0, shy} - {1'b0, dd};
  end

  // each point waits in hold_x/hold_y until the next hit or the end of
  // its line shows whether it is the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
      pend_last <= 1'b0;
      fresh <= 1'b0;
      emitted <= 1'b0;
    end else begin
      state <= state_next;
      emitted <= (state == BK_OUT) && !out_valid && pend_last;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        BK_IDLE: begin
          if (q_valid && q_ready) job <= q_data;
        end
        BK_TRIG: begin
          a <= sine_deg(wrap_deg(11'(lv.theta) + 11'sd90));
          b <= sine_deg(wrap_deg(11'(lv.theta)));
          m <= sine_deg(wrap_deg(11'(lh.theta) + 11'sd90));
          n <= sine_deg(wrap_deg(11'(lh.theta)));
          d <= sine_deg(wrap_deg(11'(lv.theta) - 11'(lh.theta)));
        end
        BK_MUL: begin
          pb <= 32'(lh.rho) * 32'(b);
          nc <= 32'(n) * 32'(lv.rho);
          mc <= 32'(m) * 32'(lv.rho);
          pa <= 32'(lh.rho) * 32'(a);
        end
        BK_SUM: begin
          if (d < 0) begin
            nx <= NumW'(nc) - NumW'(pb);
            ny <= NumW'(pa) - NumW'(mc);
            dd <= -NumW'(d);
          end else begin
            nx <= NumW'(pb) - NumW'(nc);
            ny <= NumW'(mc) - NumW'(pa);
            dd <= NumW'(d);
          end
        end
        BK_CHECK: begin
          // quotient fits in ImgW + CoordFrac bits, so the top of the
          // dividend starts in the remainder
          remx <= {{ImgW{1'b0}}, nx[NumW-1:ImgW]};
          remy <= {{ImgW{1'b0}}, ny[NumW-1:ImgW]};
          qx <= {nx[ImgW-1:0], {(NumW-ImgW){1'b0}}};
          qy <= {ny[ImgW-1:0], {(NumW-ImgW){1'b0}}};
          step <= '0;
          fresh <= hit;
        end
        BK_DIV: begin
          step <= step + 1'b1;
          if (trx[NumW]) begin
            remx <= shx;
            qx <= {qx[NumW-2:0], 1'b0};
          end else begin
            remx <= trx[NumW-1:0];
            qx <= {qx[NumW-2:0], 1'b1};
          end
          if (try_[NumW]) begin
            remy <= shy;
            qy <= {qy[NumW-2:0], 1'b0};
          end else begin
            remy <= try_[NumW-1:0];
            qy <= {qy[NumW-2:0], 1'b1};
          end
        end
        BK_OUT: begin
          if (!out_valid) begin
            if (fresh) begin
              fresh <= 1'b0;
              if (pend_last) begin
                out_valid <= 1'b1;
                out_x <= hold_x;
                out_y <= hold_y;
                out_last <= 1'b0;
              end
              hold_x <= rx;
              hold_y <= ry;
              pend_last <= 1'b1;
            end else if (pend_last) begin
              out_valid <= 1'b1;
              out_x <= hold_x;
              out_y <= hold_y;
              out_last <= 1'b1;
              pend_last <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign limx = image_width * dd[TrigW-1:0];
  assign limy = image_height * dd[TrigW-1:0];
  assign hit = (dd != 0) && (nx > 0) && (ny > 0)
               && (nx < $signed(NumW'(limx)))
               && (ny < $signed(NumW'(limy)));

endmodule

// File: bench/hlpi_checker.sv
`timescale 1ns / 1ps

module hlpi_checker
  import hlpi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [ImgW-1:0] cfg_data,
  hlpi_if line_ch,
  hlpi_if point_ch,
  output int lines_taken,
  output int points_due,
  output int errors
);

  typedef struct {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic last;
  } point_t;

  localparam int StoreDepth = MaxLinesDefault;

  longint trig_q14[91];
  point_t expected_points[$];
  logic signed [RhoW-1:0] kept_rho[StoreDepth];
  logic [ThetaW-1:0] kept_theta[StoreDepth];
  bit kept_vert[StoreDepth];
  int kept_lines;
  longint img_w, img_h;

  // one-degree rotation in Q2.30, rounded half up
  initial begin
    longint c, s, nc, ns;
    c = longint'(1) << 30;
    s = 0;
    for (int k = 0; k <= 45; k++) begin
      trig_q14[k] = (s + 32768) >>> 16;
      trig_q14[90 - k] = (c + 32768) >>> 16;
      nc = (c * 64'sd1073578288 - s * 64'sd18739379 + (longint'(1) << 29)) >>> 30;
      ns = (s * 64'sd1073578288 + c * 64'sd18739379 + (longint'(1) << 29)) >>> 30;
      c = nc;
      s = ns;
    end
  end

  function automatic longint sin_of(int deg);
    int r;
    r = deg % 360;
    if (r < 0) r += 360;
    if (r <= 90) return trig_q14[r];
    if (r <= 180) return trig_q14[180 - r];
    if (r <= 270) return -trig_q14[r - 180];
    return -trig_q14[360 - r];
  endfunction

  function automatic logic [CoordW-1:0] to_q4(longint num, longint den);
    longint q;
    q = (num * (longint'(1) << CoordFracDefault)) / den;
    if (q > 65535) q = 65535;
    return q[CoordW-1:0];
  endfunction

  function automatic bit cross_point(int rv, int tv, int rh, int th,
                                     output logic [CoordW-1:0] px,
                                     output logic [CoordW-1:0] py);
    longint a, b, m, n, nx, ny, d;
    a = sin_of(tv + 90);
    b = sin_of(tv);
    m = sin_of(th + 90);
    n = sin_of(th);
    nx = rh * b - n * rv;
    ny = m * rv - rh * a;
    d = sin_of(tv - th);
    px = '0;
    py = '0;
    if (d == 0) return 0;
    if (d < 0) begin
      d = -d;
      nx = -nx;
      ny = -ny;
    end
    if (nx <= 0 || ny <= 0) return 0;
    if (nx >= img_w * d || ny >= img_h * d) return 0;
    px = to_q4(nx, d);
    py = to_q4(ny, d);
    return 1;
  endfunction

  function automatic void predict_points(logic signed [RhoW-1:0] rho,
                                         logic [ThetaW-1:0] theta, logic clear);
    bit vert, hit;
    int first;
    point_t p;
    vert = (theta < 45) || (theta > 135);
    first = expected_points.size();
    if (clear) kept_lines = 0;
    if (kept_lines >= StoreDepth) return;
    for (int i = 0; i < kept_lines; i++) begin
      if (kept_vert[i] == vert) continue;
      if (vert)
        hit = cross_point(rho, theta, kept_rho[i], kept_theta[i], p.x, p.y);
      else
        hit = cross_point(kept_rho[i], kept_theta[i], rho, theta, p.x, p.y);
      if (hit) begin
        p.last = 1'b0;
        expected_points.insert(expected_points.size(), p);
      end
    end
    if (expected_points.size() > first)
      expected_points[expected_points.size() - 1].last = 1'b1;
    kept_rho[kept_lines] = rho;
    kept_theta[kept_lines] = theta;
    kept_vert[kept_lines] = vert;
    kept_lines++;
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      kept_lines = 0;
      img_w = longint'(WidthReset);
      img_h = longint'(HeightReset);
      lines_taken <= 0;
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgIdxWidth) img_w = longint'(cfg_data);
        else img_h = longint'(cfg_data);
      end
      if (point_ch.valid && point_ch.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point beat x=%0d y=%0d", point_ch.data[32:17],
                 point_ch.data[16:1]);
          errors <= errors + 1;
        end else begin
          want = expected_points.pop_front();
          if (want.x !== point_ch.data[32:17] || want.y !== point_ch.data[16:1] ||
              want.last !== point_ch.data[0]) begin
            if (want.x !== point_ch.data[32:17])
              $error("point_x: expected %0d, got %0d", want.x, point_ch.data[32:17]);
            if (want.y !== point_ch.data[16:1])
              $error("point_y: expected %0d, got %0d", want.y, point_ch.data[16:1]);
            if (want.last !== point_ch.data[0])
              $error("last_point: expected %0b, got %0b", want.last, point_ch.data[0]);
            errors <= errors + 1;
          end
        end
      end
      if (line_ch.valid && line_ch.ready) begin
        predict_points(line_ch.data[22:9], line_ch.data[8:1], line_ch.data[0]);
        lines_taken <= lines_taken + 1;
      end
    end
    points_due <= expected_points.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hlpi_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [ImgW-1:0] cfg_data;
  int lines_taken, points_due, errors;
  int burst_left;
  int stall_run;
  bit stall_mode;
  int img_w, img_h;

  hlpi_if #(.W(23)) line_ch ();
  hlpi_if #(.W(33)) point_ch ();

  hough_line_pair_intersection uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .line_in_valid(line_ch.valid),
    .line_in_ready(line_ch.ready),
    .rho(line_ch.data[22:9]),
    .theta_deg(line_ch.data[8:1]),
    .new_set(line_ch.data[0]),
    .point_out_valid(point_ch.valid),
    .point_out_ready(point_ch.ready),
    .point_x(point_ch.data[32:17]),
    .point_y(point_ch.data[16:1]),
    .last_point(point_ch.data[0])
  );

  hlpi_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .line_ch(line_ch),
    .point_ch(point_ch),
    .lines_taken(lines_taken),
    .points_due(points_due),
    .errors(errors)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver stalls: runs of random stalls, runs of steady ready
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = ($urandom_range(0, 3) != 0);
      stall_run = $urandom_range(1, 200);
    end
    stall_run--;
    point_ch.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  task automatic send_line(logic signed [RhoW-1:0] r, logic [ThetaW-1:0] t, logic ns);
    int target;
    if (burst_left == 0) begin
      line_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    line_ch.valid <= 1'b1;
    line_ch.data <= {r, t, ns};
    target = lines_taken + 1;
    do @(negedge clk); while (lines_taken != target);
  endtask

  task automatic drain();
    line_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (points_due != 0);
    repeat (2000) @(negedge clk);
  endtask

  task automatic set_image(int w, int h);
    cfg_we <= 1'b1;
    cfg_index <= CfgIdxWidth;
    cfg_data <= w[ImgW-1:0];
    @(negedge clk);
    cfg_index <= CfgIdxHeight;
    cfg_data <= h[ImgW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    img_w = w;
    img_h = h;
  endtask

  task automatic random_lines(int count, int first_set);
    int set_left, span, k;
    logic signed [RhoW-1:0] r;
    logic [ThetaW-1:0] t;
    span = (img_w > img_h) ? img_w : img_h;
    span = (span < 8) ? 8 : ((span > 8000) ? 8000 : span + 40);
    set_left = first_set;
    repeat (count) begin
      k = $urandom_range(0, 99);
      if (k < 80) begin
        t = ThetaW'($urandom_range(0, 179));
        r = RhoW'($urandom_range(0, span));
      end else if (k < 90) begin
        t = ThetaW'($urandom_range(0, 255));
        r = RhoW'($urandom);
      end else begin
        t = ThetaW'($urandom_range(0, 179));
        r = RhoW'(-$signed($urandom_range(0, span)));
      end
      send_line(r, t, set_left == 0);
      if (set_left == 0) set_left = $urandom_range(2, 20);
      set_left--;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CfgIdxWidth;
    cfg_data = '0;
    line_ch.valid = 1'b0;
    line_ch.data = '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_image(640, 480);

    send_line(14'sd100, 8'd0, 1'b1);
    send_line(14'sd50, 8'd90, 1'b0);
    send_line(-14'sd200, 8'd179, 1'b0);
    send_line(14'sd300, 8'd45, 1'b0);
    send_line(14'sd8191, 8'd135, 1'b0);
    send_line(-14'sd8192, 8'd44, 1'b0);
    send_line(14'sd400, 8'd136, 1'b0);
    send_line(14'sd0, 8'd255, 1'b0);
    send_line(14'sd639, 8'd0, 1'b0);
    send_line(14'sd479, 8'd90, 1'b0);
    // parallel pair: difference of 180 degrees
    send_line(14'sd10, 8'd230, 1'b1);
    send_line(14'sd10, 8'd50, 1'b0);
    send_line(14'sd200, 8'd120, 1'b1);
    send_line(14'sd150, 8'd10, 1'b0);
    send_line(14'sd320, 8'd170, 1'b0);
    send_line(14'sd240, 8'd60, 1'b0);
    send_line(14'sd0, 8'd90, 1'b0);
    send_line(14'sd0, 8'd0, 1'b0);
    drain();

    // random sets of up to 20 lines, none of which fills the store
    random_lines(70, 0);
    drain();
    set_image(4095, 4095);
    random_lines(60, 0);
    drain();
    set_image(1, 1);
    random_lines(40, 0);
    drain();
    set_image(0, 300);
    random_lines(30, 0);
    drain();
    set_image(300, 0);
    random_lines(30, 0);
    drain();
    set_image(4095, 100);
    random_lines(60, 0);
    drain();
    set_image($urandom_range(1, 4095), $urandom_range(1, 4095));
    random_lines(60, 0);
    drain();
    set_image(640, 480);
    random_lines(70, 0);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule
